>>> design/affine_matrix_inverse_unit_macros.svh
// Assertion macros used by amiu_back of the affine matrix inverse unit.
// Needs a clk and an active-high rst in the scope that uses them.
`ifndef AFFINE_MATRIX_INVERSE_UNIT_MACROS_SVH
`define AFFINE_MATRIX_INVERSE_UNIT_MACROS_SVH

// same-cycle implication
`define AMIU_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define AMIU_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> design/amiu_pkg.sv
// Types, widths and helpers for the affine matrix inverse unit.
// No dependencies; every design module imports this package.
`default_nettype none
package amiu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  localparam int PROD_BITS  = 2 * WORD_BITS;
  localparam int COF_BITS   = 2 * WORD_BITS + 1;
  localparam int PART_BITS  = 2 * WORD_BITS + 1;
  localparam int DET_BITS   = 3 * WORD_BITS + 3;
  localparam int NUM_ENTRY  = COF_BITS + 2 * FRAC_BITS;
  localparam int NUM_SHIFT  = DET_BITS + FRAC_BITS + 1;
  localparam int NUM_BITS   = (NUM_ENTRY > NUM_SHIFT) ? NUM_ENTRY : NUM_SHIFT;
  localparam int REM_BITS   = (NUM_BITS > DET_BITS + WORD_BITS) ?
                              NUM_BITS : DET_BITS + WORD_BITS;
  localparam int LANE_LAT   = WORD_BITS + 2;
  localparam int Q_DEPTH    = 2;
  localparam int OUT_DEPTH  = 2;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic        [WORD_BITS-1:0] mag_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [COF_BITS-1:0]  cof_t;
  typedef logic signed [PART_BITS-1:0] part_t;
  typedef logic signed [DET_BITS-1:0]  det_t;
  typedef logic signed [NUM_BITS-1:0]  num_t;
  typedef logic        [REM_BITS-1:0]  rem_t;
  typedef logic        [1:0]           row_t;

  localparam row_t ROW_FIRST = 2'd0;
  localparam row_t ROW_MID   = 2'd1;
  localparam row_t ROW_LAST  = 2'd2;

  // cyclic neighbours used for cofactors
  localparam int NEXT1 [3] = '{1, 2, 0};
  localparam int NEXT2 [3] = '{2, 0, 1};

  localparam word_t WORD_MAX  = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam word_t WORD_MIN  = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});
  localparam mag_t  MAG_HALF  = mag_t'({1'b1, {(WORD_BITS-1){1'b0}}});
  localparam mag_t  MAG_HALFM = mag_t'({1'b0, {(WORD_BITS-1){1'b1}}});

  typedef struct packed {
    word_t [2:0][2:0] a;
    word_t [2:0]      t;
  } mat_t;

  typedef struct packed {
    cof_t [2:0][2:0] cof;
    det_t            det;
    det_t [2:0]      tsum;
  } item_t;

  typedef struct packed {
    logic v;
    row_t row;
    logic sing;
    logic last;
  } side_t;

  typedef struct packed {
    row_t        row;
    word_t [3:0] val;
    logic        sing;
    logic        clip;
    logic        last;
  } res_t;

  typedef struct packed {
    word_t val;
    logic  clip;
  } sat_t;

  // magnitude below 2^WORD_BITS unless ovf; apply sign and clamp
  function automatic sat_t saturate(mag_t q, logic ovf, logic neg);
    sat_t r;
    r.clip = 1'b0;
    r.val  = word_t'(q);
    if (ovf) begin
      r.clip = 1'b1;
      r.val  = neg ? WORD_MIN : WORD_MAX;
    end else if (neg) begin
      if (q > MAG_HALF) begin
        r.clip = 1'b1;
        r.val  = WORD_MIN;
      end else begin
        r.val = word_t'(~q + mag_t'(1));
      end
    end else if (q > MAG_HALFM) begin
      r.clip = 1'b1;
      r.val  = WORD_MAX;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/affine_matrix_inverse_unit.sv
// Affine 3x4 inverse, Q16.16: one matrix in, three rows out (row 0, 1, 2).
// Rows leave in order on the single result port, which carries one row per cycle
// unless the result buffer is full; a new matrix can be pushed before the rows
// of the one before it are all out.
// Reset (synchronous, rst high) empties both queues and all pipelines.
// Depends on amiu_pkg, amiu_front, amiu_queue, amiu_back, amiu_div_lane.
`default_nettype none
module affine_matrix_inverse_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic signed [31:0]    m00,
  input  logic signed [31:0]    m01,
  input  logic signed [31:0]    m02,
  input  logic signed [31:0]    m03,
  input  logic signed [31:0]    m10,
  input  logic signed [31:0]    m11,
  input  logic signed [31:0]    m12,
  input  logic signed [31:0]    m13,
  input  logic signed [31:0]    m20,
  input  logic signed [31:0]    m21,
  input  logic signed [31:0]    m22,
  input  logic signed [31:0]    m23,
  output logic                  empty,
  input  logic                  pop,
  output amiu_pkg::row_t        row_index,
  output amiu_pkg::word_t       inv_col0,
  output amiu_pkg::word_t       inv_col1,
  output amiu_pkg::word_t       inv_col2,
  output amiu_pkg::word_t       inv_shift,
  output logic                  singular,
  output logic                  clipped,
  output logic                  last_row
);
  import amiu_pkg::*;

  // Request flow: the front end takes a matrix per cycle while it can and
  // works out the nine cofactors, the determinant and the three translation
  // sums exactly (four stages, 32x33 partial products, registered between).
  // A two-entry queue decouples it from the back end, which sends one row
  // per cycle while not stalled into four pipelined dividers (three entries
  // plus translation). Quotients truncate toward zero, then saturate; a zero
  // determinant gives zero rows with the singular flag. Results wait in a
  // two-entry buffer so the divider pipeline stalls only when it is full.

  mat_t  mat;
  item_t f_item, q_dout;
  logic  f_push, q_full, q_empty, q_pop;
  res_t  res;

  assign mat.a[0][0] = m00;
  assign mat.a[0][1] = m01;
  assign mat.a[0][2] = m02;
  assign mat.a[1][0] = m10;
  assign mat.a[1][1] = m11;
  assign mat.a[1][2] = m12;
  assign mat.a[2][0] = m20;
  assign mat.a[2][1] = m21;
  assign mat.a[2][2] = m22;
  assign mat.t[0]    = m03;
  assign mat.t[1]    = m13;
  assign mat.t[2]    = m23;

  amiu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_push (push),
    .in_mat  (mat),
    .in_full (full),
    .q_push  (f_push),
    .q_item  (f_item),
    .q_full  (q_full)
  );

  amiu_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  amiu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (q_dout),
    .q_pop     (q_pop),
    .out_pop   (pop),
    .out_empty (empty),
    .out_res   (res)
  );

  assign row_index = res.row;
  assign inv_col0  = res.val[0];
  assign inv_col1  = res.val[1];
  assign inv_col2  = res.val[2];
  assign inv_shift = res.val[3];
  assign singular  = res.sing;
  assign clipped   = res.clip;
  assign last_row  = res.last;

endmodule
`default_nettype wire

>>> design/amiu_front.sv
// Front end: cofactors, determinant and translation sums, four stages.
// Uses amiu_pkg; feeds amiu_queue.
`default_nettype none
module amiu_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_push,
  input  amiu_pkg::mat_t in_mat,
  output logic           in_full,
  output logic           q_push,
  output amiu_pkg::item_t q_item,
  input  logic           q_full
);
  import amiu_pkg::*;

  logic  en;
  logic  v1, v2, v3, v4;
  prod_t p1 [3][3][2];
  word_t a1 [3];
  word_t t1 [3];
  cof_t  c2 [3][3];
  word_t a2 [3];
  word_t t2 [3];
  part_t dlo3 [3];
  part_t dhi3 [3];
  part_t slo3 [3][3];
  part_t shi3 [3][3];
  cof_t  c3 [3][3];
  cof_t  c4 [3][3];
  det_t  det4;
  det_t  ts4 [3];

  function automatic det_t join_part(part_t hi, part_t lo);
    return (det_t'(hi) <<< WORD_BITS) + det_t'(lo);
  endfunction

  assign en      = !(v4 && q_full);
  assign in_full = !en;
  assign q_push  = v4 && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_push;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        a1[r] <= $signed(in_mat.a[0][r]);
        t1[r] <= $signed(in_mat.t[r]);
        a2[r] <= a1[r];
        t2[r] <= t1[r];
        for (int c = 0; c < 3; c++) begin
          p1[r][c][0] <= $signed(in_mat.a[NEXT1[r]][NEXT1[c]]) *
                         $signed(in_mat.a[NEXT2[r]][NEXT2[c]]);
          p1[r][c][1] <= $signed(in_mat.a[NEXT1[r]][NEXT2[c]]) *
                         $signed(in_mat.a[NEXT2[r]][NEXT1[c]]);
          c2[r][c] <= cof_t'(p1[r][c][0]) - cof_t'(p1[r][c][1]);
          c3[r][c] <= c2[r][c];
          c4[r][c] <= c3[r][c];
        end
      end
      // cofactor split into signed high and unsigned low halves
      for (int c = 0; c < 3; c++) begin
        dlo3[c] <= a2[c] * $signed({1'b0, c2[0][c][WORD_BITS-1:0]});
        dhi3[c] <= a2[c] * $signed(c2[0][c][COF_BITS-1:WORD_BITS]);
      end
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          slo3[r][k] <= t2[k] * $signed({1'b0, c2[k][r][WORD_BITS-1:0]});
          shi3[r][k] <= t2[k] * $signed(c2[k][r][COF_BITS-1:WORD_BITS]);
        end
      end
      det4 <= join_part(dhi3[0], dlo3[0]) + join_part(dhi3[1], dlo3[1]) +
              join_part(dhi3[2], dlo3[2]);
      for (int r = 0; r < 3; r++) begin
        ts4[r] <= join_part(shi3[r][0], slo3[r][0]) +
                  join_part(shi3[r][1], slo3[r][1]) +
                  join_part(shi3[r][2], slo3[r][2]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      q_item.tsum[r] = ts4[r];
      for (int c = 0; c < 3; c++) begin
        q_item.cof[r][c] = c4[r][c];
      end
    end
    q_item.det = det4;
  end

endmodule
`default_nettype wire

>>> design/amiu_queue.sv
// Two-entry request queue between front and back ends.
// Uses amiu_pkg.
`default_nettype none
module amiu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  amiu_pkg::item_t din,
  output logic            full,
  input  logic            pop,
  output amiu_pkg::item_t dout,
  output logic            empty
);
  import amiu_pkg::*;

  item_t      mem [Q_DEPTH];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full  = cnt == 2'(Q_DEPTH);
  assign empty = cnt == 2'd0;
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

>>> design/amiu_div_lane.sv
// Pipelined restoring divider lane: magnitude quotient, overflow, sign.
// Uses amiu_pkg; its registers advance only while en is high.
`default_nettype none
module amiu_div_lane (
  input  logic           clk,
  input  logic           en,
  input  amiu_pkg::num_t num,
  input  amiu_pkg::det_t den,
  output amiu_pkg::mag_t q,
  output logic           ovf,
  output logic           neg
);
  import amiu_pkg::*;

  logic [NUM_BITS-1:0] nm;
  logic [DET_BITS-1:0] dma;
  logic                nga;
  rem_t                rm  [WORD_BITS+1];
  logic [DET_BITS-1:0] dm  [WORD_BITS+1];
  mag_t                qm  [WORD_BITS+1];
  logic                ov  [WORD_BITS+1];
  logic                ng  [WORD_BITS+1];
  rem_t                dsh [WORD_BITS];
  rem_t                dif [WORD_BITS];
  logic                ge  [WORD_BITS];

  always_comb begin
    for (int s = 0; s < WORD_BITS; s++) begin
      dsh[s] = rem_t'(dm[s]) << (WORD_BITS - 1 - s);
      ge[s]  = rm[s] >= dsh[s];
      dif[s] = rm[s] - dsh[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm  <= num[NUM_BITS-1] ? NUM_BITS'(~num + 1'b1) : NUM_BITS'(num);
      dma <= den[DET_BITS-1] ? DET_BITS'(~den + 1'b1) : DET_BITS'(den);
      nga <= num[NUM_BITS-1] ^ den[DET_BITS-1];
      // quotient of 2^WORD_BITS or more saturates whatever the sign
      rm[0] <= rem_t'(nm);
      dm[0] <= dma;
      qm[0] <= '0;
      ov[0] <= rem_t'(nm) >= (rem_t'(dma) << WORD_BITS);
      ng[0] <= nga;
      for (int s = 0; s < WORD_BITS; s++) begin
        rm[s+1] <= ge[s] ? dif[s] : rm[s];
        dm[s+1] <= dm[s];
        qm[s+1] <= {qm[s][WORD_BITS-2:0], ge[s]};
        ov[s+1] <= ov[s];
        ng[s+1] <= ng[s];
      end
    end
  end

  assign q   = qm[WORD_BITS];
  assign ovf = ov[WORD_BITS];
  assign neg = ng[WORD_BITS];

endmodule
`default_nettype wire

>>> design/amiu_back.sv
// Back end: row sequencer, four divider lanes, saturation, result buffer.
// Uses amiu_pkg, amiu_div_lane and the assertion macro header.
`default_nettype none
`include "affine_matrix_inverse_unit_macros.svh"
module amiu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  amiu_pkg::item_t q_item,
  output logic            q_pop,
  input  logic            out_pop,
  output logic            out_empty,
  output amiu_pkg::res_t  out_res
);
  import amiu_pkg::*;

  row_t       rc;
  logic       en, issue;
  side_t      sb [LANE_LAT+1];
  num_t       n0 [4];
  det_t       d0;
  mag_t       qv [4];
  logic       ovv [4];
  logic       ngv [4];
  sat_t       sv [4];
  res_t       res_new;
  res_t       ob [OUT_DEPTH];
  logic       owp, orp;
  logic [1:0] ocnt;
  logic       ofull, opush, opop;

  function automatic cof_t pick_cof(item_t it, int k, row_t r);
    case (r)
      ROW_MID:  return it.cof[k][1];
      ROW_LAST: return it.cof[k][2];
      default:  return it.cof[k][0];
    endcase
  endfunction

  function automatic det_t pick_sum(item_t it, row_t r);
    case (r)
      ROW_MID:  return it.tsum[1];
      ROW_LAST: return it.tsum[2];
      default:  return it.tsum[0];
    endcase
  endfunction

  assign ofull = ocnt == 2'(OUT_DEPTH);
  assign en    = !(sb[LANE_LAT].v && ofull);
  assign issue = en && !q_empty;
  assign q_pop = issue && rc == ROW_LAST;
  assign opush = sb[LANE_LAT].v && en;
  assign opop  = out_pop && ocnt != 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rc <= ROW_FIRST;
    end else if (issue) begin
      rc <= (rc == ROW_LAST) ? ROW_FIRST : rc + row_t'(1);
    end
  end

  // sideband valid bits reset; the rest of the sideband and operands do not
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LANE_LAT; i++) sb[i].v <= 1'b0;
    end else if (en) begin
      sb[0].v <= issue;
      for (int i = 0; i < LANE_LAT; i++) sb[i+1].v <= sb[i].v;
    end
    if (en) begin
      sb[0].row  <= rc;
      sb[0].sing <= q_item.det == '0;
      sb[0].last <= rc == ROW_LAST;
      for (int i = 0; i < LANE_LAT; i++) begin
        sb[i+1].row  <= sb[i].row;
        sb[i+1].sing <= sb[i].sing;
        sb[i+1].last <= sb[i].last;
      end
      for (int k = 0; k < 3; k++) begin
        n0[k] <= num_t'($signed(pick_cof(q_item, k, rc))) <<< (2 * FRAC_BITS);
      end
      n0[3] <= -(num_t'($signed(pick_sum(q_item, rc))) <<< FRAC_BITS);
      d0    <= q_item.det;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    amiu_div_lane u_lane (
      .clk (clk),
      .en  (en),
      .num (n0[k]),
      .den (d0),
      .q   (qv[k]),
      .ovf (ovv[k]),
      .neg (ngv[k])
    );
  end

  always_comb begin
    for (int k = 0; k < 4; k++) sv[k] = saturate(qv[k], ovv[k], ngv[k]);
    res_new.row  = sb[LANE_LAT].row;
    res_new.sing = sb[LANE_LAT].sing;
    res_new.last = sb[LANE_LAT].last;
    if (sb[LANE_LAT].sing) begin
      res_new.val  = '0;
      res_new.clip = 1'b0;
    end else begin
      for (int k = 0; k < 4; k++) res_new.val[k] = sv[k].val;
      res_new.clip = sv[0].clip | sv[1].clip | sv[2].clip | sv[3].clip;
    end
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      ob[owp] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (opush) owp <= !owp;
      if (opop)  orp <= !orp;
      ocnt <= ocnt + 2'(opush) - 2'(opop);
    end
  end

  assign out_empty = ocnt == 2'd0;
  assign out_res   = ob[orp];

  `AMIU_ASSERT_SAME(a_obuf_room, opush, !ofull, "result buffer overrun")
  `AMIU_ASSERT_NEXT(a_row_wrap, issue && rc == ROW_LAST, rc == ROW_FIRST, "row count did not wrap")
  `AMIU_ASSERT_SAME(a_sing_zero, !out_empty && out_res.sing, out_res.val == '0 && !out_res.clip, "singular row not zero")
  `AMIU_ASSERT_SAME(a_last_flag, !out_empty, out_res.last == (out_res.row == ROW_LAST), "last flag mismatch")

endmodule
`default_nettype wire
